[hw/rtl/sbcd_pkg.sv]
// Shared types and constants for the sync byte command deframer.
package sbcd_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;

    localparam int BYTE_W    = 8;
    localparam int CMD_W     = 3;
    localparam int OUT_IDX_W = 6;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] SYNC_A = 8'd30;
    localparam logic [BYTE_W-1:0] SYNC_B = 8'd29;
    localparam logic [BYTE_W-1:0] SYNC_C = 8'd28;

    localparam logic [BYTE_W-1:0] CMD_HID      = 8'd1;
    localparam logic [BYTE_W-1:0] CMD_WEBUSB   = 8'd2;
    localparam logic [BYTE_W-1:0] CMD_PROTOCOL = 8'd4;

    localparam logic [CMD_W-1:0] CMD_NONE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SEL_HID    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEL_WEBUSB = 3'd2;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REJECT  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_LEN_HID      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_WEBUSB   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_PROTOCOL = 2'd2;

    localparam logic [CFG_W-1:0] LEN_HID_RST      = 7'd32;
    localparam logic [CFG_W-1:0] LEN_WEBUSB_RST   = 7'd64;
    localparam logic [CFG_W-1:0] LEN_PROTOCOL_RST = 7'd1;

    typedef enum logic [2:0] {
        PH_HUNT0,
        PH_HUNT1,
        PH_HUNT2,
        PH_CMD,
        PH_PAYLOAD
    } t_phase;

    typedef struct packed {
        logic                 kind;
        logic [CMD_W-1:0]     cmd_code;
        logic [BYTE_W-1:0]    data_byte;
        logic [OUT_IDX_W-1:0] byte_index;
        logic                 last;
    } t_result;

endpackage

[hw/rtl/sync_byte_command_deframer_unit.sv]
// Sync byte command deframer: frame hunting, command decode and payload emission.
// A result is valid the cycle after its byte transfer unless the head is stalled.
// Throughput: one byte per cycle while o_stall is low; the next-state logic and the
// length compare are combinational, and a two-entry output buffer absorbs a stall.
// Reset (synchronous, active low) returns to hunting for the first sync byte,
// empties the output buffer and loads the default payload lengths.
module sync_byte_command_deframer_unit #(
    parameter int MAX_PAYLOAD = sbcd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [sbcd_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_kind,
    output logic [sbcd_pkg::CMD_W-1:0]     o_cmd_code,
    output logic [sbcd_pkg::BYTE_W-1:0]    o_data_byte,
    output logic [sbcd_pkg::OUT_IDX_W-1:0] o_byte_index,
    output logic                           o_last,
    input  logic                           i_cfg_we,
    input  logic [sbcd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sbcd_pkg::CFG_W-1:0]     i_cfg_data
);
    import sbcd_pkg::*;

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LEN_W = ($clog2(MAX_PAYLOAD + 1) > CFG_W) ? $clog2(MAX_PAYLOAD + 1) : CFG_W;
    localparam int CMP_W = ((IDX_W + 1) > LEN_W) ? (IDX_W + 1) : LEN_W;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

    t_phase            r_phase, n_phase;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CFG_W-1:0]  r_len_hid, r_len_webusb, r_len_protocol;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    logic    w_acc, w_take;
    logic    w_res_valid;
    t_result w_res;
    logic    w_cmd_ok;
    logic    w_fin;
    logic [CFG_W-1:0]     w_len_reg;
    logic [LEN_W-1:0]     w_len;
    logic [IDX_W:0]       w_idx_inc;
    logic [OUT_IDX_W-1:0] w_idx_out;

    assign o_stall = r_skid_valid;
    assign w_acc   = i_valid && !o_stall;
    assign w_take  = r_out_valid && !i_stall;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_hid      <= LEN_HID_RST;
            r_len_webusb   <= LEN_WEBUSB_RST;
            r_len_protocol <= LEN_PROTOCOL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LEN_HID:      r_len_hid      <= i_cfg_data;
                REG_LEN_WEBUSB:   r_len_webusb   <= i_cfg_data;
                REG_LEN_PROTOCOL: r_len_protocol <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // Payload length for the active command, clamped to 1 .. MAX_PAYLOAD.
    always_comb begin
        case (r_cmd)
            CMD_SEL_HID:    w_len_reg = r_len_hid;
            CMD_SEL_WEBUSB: w_len_reg = r_len_webusb;
            default:        w_len_reg = r_len_protocol;
        endcase
        if (w_len_reg == '0) begin
            w_len = LEN_W'(1);
        end else if (LEN_W'(w_len_reg) > MAX_LEN) begin
            w_len = MAX_LEN;
        end else begin
            w_len = LEN_W'(w_len_reg);
        end
    end

    assign w_idx_inc = (IDX_W + 1)'(r_idx) + (IDX_W + 1)'(1);
    assign w_fin     = CMP_W'(w_idx_inc) >= CMP_W'(w_len);
    assign w_idx_out = OUT_IDX_W'(r_idx);

    always_comb begin
        case (i_rx_byte) inside
            CMD_HID, CMD_WEBUSB, CMD_PROTOCOL: w_cmd_ok = 1'b1;
            default:                           w_cmd_ok = 1'b0;
        endcase
    end

    // Next state of the frame state machine.
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HUNT0:   n_phase = (i_rx_byte == SYNC_A) ? PH_HUNT1 : PH_HUNT0;
            PH_HUNT1:   n_phase = (i_rx_byte == SYNC_B) ? PH_HUNT2 : PH_HUNT0;
            PH_HUNT2:   n_phase = (i_rx_byte == SYNC_C) ? PH_CMD : PH_HUNT0;
            PH_CMD:     n_phase = w_cmd_ok ? PH_PAYLOAD : PH_HUNT0;
            PH_PAYLOAD: n_phase = w_fin ? PH_HUNT0 : PH_PAYLOAD;
            default:    n_phase = PH_HUNT0;
        endcase
    end

    // Outputs of the frame state machine: result item and frame counters.
    always_comb begin
        w_res_valid      = 1'b0;
        w_res.kind       = KIND_PAYLOAD;
        w_res.cmd_code   = r_cmd;
        w_res.data_byte  = i_rx_byte;
        w_res.byte_index = w_idx_out;
        w_res.last       = w_fin;
        n_cmd            = r_cmd;
        n_idx            = r_idx;
        unique case (r_phase)
            PH_CMD: begin
                n_idx = '0;
                if (w_cmd_ok) begin
                    n_cmd = i_rx_byte[CMD_W-1:0];
                end else begin
                    n_cmd            = CMD_NONE;
                    w_res_valid      = 1'b1;
                    w_res.kind       = KIND_REJECT;
                    w_res.cmd_code   = CMD_NONE;
                    w_res.byte_index = '0;
                    w_res.last       = 1'b0;
                end
            end
            PH_PAYLOAD: begin
                w_res_valid = 1'b1;
                if (w_fin) begin
                    n_cmd = CMD_NONE;
                    n_idx = '0;
                end else begin
                    n_idx = w_idx_inc[IDX_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT0;
            r_cmd   <= CMD_NONE;
            r_idx   <= '0;
        end else if (w_acc) begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_idx   <= n_idx;
        end
    end

    // Two-entry output buffer; the skid entry fills only while the head is stalled.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (w_take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (w_acc && w_res_valid) begin
            if (!n_out_valid) begin
                n_out_valid = 1'b1;
                n_out       = w_res;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = w_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid      = r_out_valid;
    assign o_kind       = r_out.kind;
    assign o_cmd_code   = r_out.cmd_code;
    assign o_data_byte  = r_out.data_byte;
    assign o_byte_index = r_out.byte_index;
    assign o_last       = r_out.last;

    a_skid_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while the head is empty");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_phase == PH_PAYLOAD && w_fin) |=> (r_phase == PH_HUNT0))
        else $error("frame did not end after its last payload byte");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (int'(r_idx) < MAX_PAYLOAD))
        else $error("payload index reached the maximum payload length");

    a_reject_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_phase == PH_CMD && !w_cmd_ok) |=>
            (o_valid && (r_cmd == CMD_NONE) && (r_phase == PH_HUNT0)))
        else $error("rejected command did not produce a result and return to hunting");

endmodule

[test/tb.sv]
// Testbench for the sync byte command deframer: directed and random byte streams checked by a built-in model.
`timescale 1ns / 1ps

module tb;
    import sbcd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [BYTE_W-1:0] CMD_BATTERY = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [BYTE_W-1:0]    i_rx_byte;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_kind;
    logic [CMD_W-1:0]     o_cmd_code;
    logic [BYTE_W-1:0]    o_data_byte;
    logic [OUT_IDX_W-1:0] o_byte_index;
    logic                 o_last;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    // Deframing model state and the results it still waits for.
    t_phase               hunt_phase;
    int                   pay_idx;
    logic [CMD_W-1:0]     pay_cmd;
    logic [CFG_W-1:0]     len_reg [3];
    t_result              expected_results [$];

    bit idle_on = 1'b1;
    int stall_hold = 0;
    int err_cnt = 0;
    int cycles = 0;
    int items_sent = 0;
    int noise_sent = 0;
    int frames_sent = 0;
    int rejects_seen = 0;
    int results_checked = 0;
    int settings_cnt = 0;

    sync_byte_command_deframer_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_cmd_code   (o_cmd_code),
        .o_data_byte  (o_data_byte),
        .o_byte_index (o_byte_index),
        .o_last       (o_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Output stall in random bursts, alternating with free-running stretches.
    always @(posedge i_clk) begin
        if (!idle_on || !i_rst_n) begin
            i_stall <= 1'b0;
            stall_hold = 0;
        end else if (stall_hold > 0) begin
            stall_hold--;
        end else if ($urandom_range(0, 2) == 0) begin
            i_stall <= 1'b1;
            stall_hold = $urandom_range(1, 14);
        end else begin
            i_stall <= 1'b0;
            stall_hold = $urandom_range(1, 40);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: kind %0d data_byte %0h",
                       o_kind, o_data_byte);
                err_cnt++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_kind);
                    err_cnt++;
                end
                if (o_cmd_code !== want.cmd_code) begin
                    $error("cmd_code: expected %0d, got %0d", want.cmd_code, o_cmd_code);
                    err_cnt++;
                end
                if (o_data_byte !== want.data_byte) begin
                    $error("data_byte: expected %0h, got %0h", want.data_byte, o_data_byte);
                    err_cnt++;
                end
                if (o_byte_index !== want.byte_index) begin
                    $error("byte_index: expected %0d, got %0d", want.byte_index,
                           o_byte_index);
                    err_cnt++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    err_cnt++;
                end
            end
        end
    end

    // A register value of zero still means one byte; anything above the maximum is clipped.
    function automatic int payload_len(input logic [CFG_W-1:0] r);
        if (r == '0)
            return 1;
        if (int'(r) > MAX_PAYLOAD_DEF)
            return MAX_PAYLOAD_DEF;
        return int'(r);
    endfunction

    function automatic int len_of_cmd(input logic [CMD_W-1:0] c);
        if (c == CMD_SEL_HID)
            return payload_len(len_reg[int'(REG_LEN_HID)]);
        if (c == CMD_SEL_WEBUSB)
            return payload_len(len_reg[int'(REG_LEN_WEBUSB)]);
        return payload_len(len_reg[int'(REG_LEN_PROTOCOL)]);
    endfunction

    function automatic logic [CFG_W-1:0] rand_len();
        if ($urandom_range(0, 3) == 0)
            return 7'($urandom_range(0, 127));
        return 7'($urandom_range(1, 8));
    endfunction

    task automatic deframe_predict(input logic [BYTE_W-1:0] b);
        t_result r;
        case (hunt_phase)
            PH_HUNT0: begin
                if (b == SYNC_A)
                    hunt_phase = PH_HUNT1;
            end
            // A byte that breaks the sync match is not retried as a first sync byte.
            PH_HUNT1: begin
                hunt_phase = (b == SYNC_B) ? PH_HUNT2 : PH_HUNT0;
            end
            PH_HUNT2: begin
                hunt_phase = (b == SYNC_C) ? PH_CMD : PH_HUNT0;
            end
            PH_CMD: begin
                if (b == CMD_HID || b == CMD_WEBUSB || b == CMD_PROTOCOL) begin
                    pay_cmd = b[CMD_W-1:0];
                    pay_idx = 0;
                    hunt_phase = PH_PAYLOAD;
                end else begin
                    r = '{kind: KIND_REJECT, cmd_code: CMD_NONE, data_byte: b,
                          byte_index: '0, last: 1'b0};
                    expected_results.push_back(r);
                    rejects_seen++;
                    hunt_phase = PH_HUNT0;
                end
            end
            default: begin
                r = '{kind: KIND_PAYLOAD, cmd_code: pay_cmd, data_byte: b,
                      byte_index: OUT_IDX_W'(pay_idx),
                      last: (pay_idx + 1 >= len_of_cmd(pay_cmd))};
                expected_results.push_back(r);
                if (r.last)
                    hunt_phase = PH_HUNT0;
                else
                    pay_idx++;
            end
        endcase
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        deframe_predict(b);
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] cmd);
        int n;
        n = 0;
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(SYNC_C);
        send_byte(cmd);
        if (cmd == CMD_HID || cmd == CMD_WEBUSB || cmd == CMD_PROTOCOL)
            n = len_of_cmd(cmd[CMD_W-1:0]);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
        frames_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_len(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx != REG_UNUSED)
            len_reg[int'(idx)] = val;
    endtask

    task automatic set_lengths(input logic [CFG_W-1:0] hid, input logic [CFG_W-1:0] web,
                               input logic [CFG_W-1:0] prot);
        drain();
        write_len(REG_LEN_HID, hid);
        write_len(REG_LEN_WEBUSB, web);
        write_len(REG_LEN_PROTOCOL, prot);
        settings_cnt++;
    endtask

    // Mostly well-formed frames with random content, some rejected commands,
    // sync prefixes broken partway, and a little line noise.
    task automatic test_random_frames(input int budget);
        int start;
        int r;
        int k;
        logic [BYTE_W-1:0] b;
        start = items_sent - noise_sent;
        while (items_sent - noise_sent - start < budget) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                case ($urandom_range(0, 2))
                    0:       send_frame(CMD_HID);
                    1:       send_frame(CMD_WEBUSB);
                    default: send_frame(CMD_PROTOCOL);
                endcase
            end else if (r < 80) begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CMD_HID || b == CMD_WEBUSB || b == CMD_PROTOCOL);
                if ($urandom_range(0, 3) == 0)
                    b = CMD_BATTERY;
                send_frame(b);
            end else if (r < 90) begin
                k = $urandom_range(1, 2);
                send_byte(SYNC_A);
                if (k == 2)
                    send_byte(SYNC_B);
                do
                    b = ($urandom_range(0, 1) == 0) ? SYNC_A : 8'($urandom_range(0, 255));
                while (b == ((k == 1) ? SYNC_B : SYNC_C));
                send_byte(b);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_byte(8'($urandom_range(0, 255)));
                    noise_sent++;
                end
            end
        end
    endtask

    // The byte that breaks a partial sync must not restart the match.
    task automatic test_sync_hunt();
        send_byte(SYNC_A);
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(SYNC_C);
        send_frame(8'hFF);
    endtask

    task automatic test_reset_lengths();
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(SYNC_C);
        send_byte(CMD_PROTOCOL);
        send_byte(8'hFF);
        test_random_frames(250);
    endtask

    task automatic test_commands();
        drain();
        write_len(REG_LEN_HID, 7'd2);
        write_len(REG_LEN_WEBUSB, 7'd0);
        write_len(REG_LEN_PROTOCOL, 7'd1);
        write_len(REG_UNUSED, 7'd0);
        settings_cnt++;
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(SYNC_C);
        send_byte(CMD_HID);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(SYNC_C);
        send_byte(CMD_WEBUSB);
        send_byte(8'hAA);
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(SYNC_C);
        send_byte(CMD_PROTOCOL);
        send_byte(8'h55);
        send_frame(CMD_BATTERY);
        send_frame(8'h00);
    endtask

    task automatic test_length_extremes();
        set_lengths(7'd1, 7'd1, 7'd1);
        test_random_frames(200);
        set_lengths(7'd64, 7'd64, 7'd64);
        test_random_frames(200);
        set_lengths(7'd0, 7'd127, 7'd65);
        test_random_frames(200);
    endtask

    task automatic test_random_lengths();
        for (int p = 0; p < 3; p++) begin
            set_lengths(rand_len(), rand_len(), rand_len());
            if (p == 2)
                idle_on = 1'b0;
            test_random_frames(200);
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_rx_byte   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        hunt_phase = PH_HUNT0;
        pay_idx    = 0;
        pay_cmd    = CMD_NONE;
        len_reg[int'(REG_LEN_HID)]      = LEN_HID_RST;
        len_reg[int'(REG_LEN_WEBUSB)]   = LEN_WEBUSB_RST;
        len_reg[int'(REG_LEN_PROTOCOL)] = LEN_PROTOCOL_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_sync_hunt();
        test_reset_lengths();
        test_commands();
        test_length_extremes();
        test_random_lengths();

        drain();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d bytes (%0d of them noise) in %0d frames across %0d length settings.",
                 items_sent, noise_sent, frames_sent, settings_cnt + 1);
        $display("Checked %0d results, %0d of them rejected commands.",
                 results_checked, rejects_seen);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/sbcd_pkg.sv
hw/rtl/sync_byte_command_deframer_unit.sv
test/tb.sv
